// ===== hdl/paired_covariance_accumulator_top_defines.svh =====
// Assertion macros shared by the covariance accumulator modules.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef PAIRED_COVARIANCE_ACCUMULATOR_TOP_DEFINES_SVH
`define PAIRED_COVARIANCE_ACCUMULATOR_TOP_DEFINES_SVH

// Condition holds at every clock edge.
`define PCA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PCA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define PCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pca_pkg.sv =====
package pca_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int DEV_W     = 17;
    localparam int PROD_W    = 34;
    localparam int SUM_W     = 48;
    localparam int CNT_OUT_W = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;
    localparam int DIV_STEPS = 48;
    localparam int STEP_W    = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_B = 2'd1;

    // Q8.8 to Q16.16 scale for a lone deviation
    localparam logic signed [DEV_W-1:0] LONE_SCALE = 17'sd256;

    typedef enum logic [2:0] {
        S_ACC,
        S_DRAIN,
        S_LOAD,
        S_DIV,
        S_EMIT
    } t_pca_state;

    typedef struct packed {
        logic accept;
        logic div_load;
        logic out_load;
    } t_pca_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_pca_sts;

endpackage

// ===== hdl/pca_dpath.sv =====
`include "paired_covariance_accumulator_top_defines.svh"

module pca_dpath
    import pca_pkg::*;
#(
    parameter int MAX_SAMPLES = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // value_a, value_b
    input  logic [S_TUSER_W-1:0] i_s_tuser,   // missing_a, missing_b
    input  t_pca_cmd             i_cmd,
    output t_pca_sts             o_sts,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // covariance, sample_count, zero pad
    output logic [M_TUSER_W-1:0] o_m_tuser    // no_samples, saturated
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int XW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SAMPLES);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    // configuration
    logic signed [SAMPLE_W-1:0] r_mean_a;
    logic signed [SAMPLE_W-1:0] r_mean_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean_a <= '0;
            r_mean_b <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MEAN_A) begin
                r_mean_a <= i_cfg_data;
            end else if (i_cfg_idx == CFG_MEAN_B) begin
                r_mean_b <= i_cfg_data;
            end
        end
    end

    // stage 1: deviations and one shared multiplier
    logic signed [SAMPLE_W-1:0] w_val_a;
    logic signed [SAMPLE_W-1:0] w_val_b;
    logic signed [DEV_W-1:0]    w_dev_a;
    logic signed [DEV_W-1:0]    w_dev_b;
    logic signed [DEV_W-1:0]    w_mul_x;
    logic signed [DEV_W-1:0]    w_mul_y;
    logic signed [PROD_W-1:0]   w_prod;
    logic                       w_has_a;
    logic                       w_has_b;

    assign w_val_a = i_s_tdata[SAMPLE_W-1:0];
    assign w_val_b = i_s_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign w_has_a = !i_s_tuser[0];
    assign w_has_b = !i_s_tuser[1];
    assign w_dev_a = DEV_W'(w_val_a) - DEV_W'(r_mean_a);
    assign w_dev_b = DEV_W'(w_val_b) - DEV_W'(r_mean_b);
    assign w_mul_x = w_has_a ? w_dev_a : w_dev_b;
    assign w_mul_y = (w_has_a && w_has_b) ? w_dev_b : LONE_SCALE;
    assign w_prod  = w_mul_x * w_mul_y;

    logic signed [PROD_W-1:0] r_term;
    logic                     r_term_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_vld <= 1'b0;
        end else begin
            r_term_vld <= i_cmd.accept && (w_has_a || w_has_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_term <= w_prod;
        end
    end

    // stage 2: saturating accumulate and count
    logic signed [SUM_W-1:0] r_sum;
    logic [CW-1:0]           r_count;
    logic                    r_ovf;
    logic signed [SUM_W:0]   w_sum_wide;
    logic                    w_sum_ovf;
    logic signed [SUM_W-1:0] w_sum_next;
    logic                    w_cnt_full;

    assign w_sum_wide = $signed({r_sum[SUM_W-1], r_sum})
                      + $signed({{(SUM_W + 1 - PROD_W){r_term[PROD_W-1]}}, r_term});
    assign w_sum_ovf  = w_sum_wide[SUM_W] != w_sum_wide[SUM_W-1];
    assign w_sum_next = !w_sum_ovf ? w_sum_wide[SUM_W-1:0] :
                        w_sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} :
                                            {1'b0, {(SUM_W - 1){1'b1}}};
    assign w_cnt_full = r_count >= CNT_MAX;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.div_load) begin
            r_sum   <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (r_term_vld) begin
            r_sum   <= w_sum_next;
            r_count <= w_cnt_full ? r_count : r_count + 1'b1;
            r_ovf   <= r_ovf || w_sum_ovf || w_cnt_full;
        end
    end

    // restoring divider: one quotient bit per cycle on the magnitude
    logic [SUM_W-1:0]  r_quo;
    logic [CW-1:0]     r_rem;
    logic [CW-1:0]     r_div_d;
    logic              r_neg;
    logic [CW-1:0]     r_snap_cnt;
    logic              r_snap_sat;
    logic              r_snap_nos;
    logic              r_div_busy;
    logic [STEP_W-1:0] r_step;
    logic [CW:0]       w_rem_sh;
    logic              w_ge;
    logic [CW:0]       w_rem_nx;

    assign w_rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_div_d};
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_div_d}) : w_rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_step     <= '0;
        end else if (i_cmd.div_load) begin
            r_div_busy <= 1'b1;
            r_step     <= '0;
        end else if (r_div_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_LAST) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_neg      <= r_sum[SUM_W-1];
            r_quo      <= r_sum[SUM_W-1] ? -r_sum : r_sum;
            r_rem      <= '0;
            r_div_d    <= r_count;
            r_snap_cnt <= r_count;
            r_snap_sat <= r_ovf;
            r_snap_nos <= r_count == '0;
        end else if (r_div_busy) begin
            r_rem <= w_rem_nx[CW-1:0];
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
        end
    end

    // output register
    logic [SUM_W-1:0]     w_cov;
    logic [XW-1:0]        w_cnt_x;
    logic                 r_out_vld;
    logic [SUM_W-1:0]     r_out_cov;
    logic [CNT_OUT_W-1:0] r_out_cnt;
    logic                 r_out_nos;
    logic                 r_out_sat;

    assign w_cov   = r_snap_nos ? '0 : (r_neg ? -r_quo : r_quo);
    assign w_cnt_x = XW'(r_snap_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_cov <= w_cov;
            r_out_cnt <= w_cnt_x[CNT_OUT_W-1:0];
            r_out_nos <= r_snap_nos;
            r_out_sat <= r_snap_sat;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(M_TDATA_W - SUM_W - CNT_OUT_W){1'b0}}, r_out_cnt, r_out_cov};
    assign o_m_tuser  = {r_out_sat, r_out_nos};

    assign o_sts.div_done = r_div_busy && (r_step == STEP_LAST);
    assign o_sts.out_free = !r_out_vld || i_m_tready;

    `PCA_ASSERT_ALWAYS(a_cnt_bound, r_count <= CNT_MAX, "pair count beyond bound")
    `PCA_ASSERT_IMPLY(a_load_idle, i_cmd.div_load, !r_term_vld && !r_div_busy, "load with work pending")
    `PCA_ASSERT_NEXT(a_out_vld, i_cmd.out_load, r_out_vld, "result load did not raise valid")

endmodule

// ===== hdl/pca_ctrl.sv =====
`include "paired_covariance_accumulator_top_defines.svh"

module pca_ctrl
    import pca_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    input  logic     i_s_tlast,
    output logic     o_s_tready,
    input  t_pca_sts i_sts,
    output t_pca_cmd o_cmd
);

    t_pca_state r_state;
    t_pca_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_s_tready     = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.div_load = 1'b0;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            S_ACC: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
                if (i_s_tvalid && i_s_tlast) begin
                    n_state = S_DRAIN;
                end
            end
            // let the last term reach the sum
            S_DRAIN: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_EMIT;
                end
            end
            // hold until the output register frees up
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    `PCA_ASSERT_IMPLY(a_drain_src, r_state == S_DRAIN, $past(i_s_tvalid && i_s_tlast && o_s_tready), "drain without last transfer")
    `PCA_ASSERT_IMPLY(a_done_in_div, i_sts.div_done, r_state == S_DIV, "divider done outside divide")

endmodule

// ===== hdl/paired_covariance_accumulator_top.sv =====
// Paired covariance accumulator.
// Slave stream: tdata carries value_a [15:0] and value_b [31:16] (signed Q8.8),
// tuser carries missing_a [0] and missing_b [1], tlast closes a run.
// Master stream: one transfer per run; tdata carries covariance [47:0]
// (signed Q32.16) and sample_count [64:48]; tuser carries no_samples [0] and
// saturated [1].
// Config port: write i_cfg_data to mean_a (index 0) or mean_b (index 1) while
// idle; other indexes are ignored.
// Throughput: one pair per cycle inside a run. The closing pair starts a
// shift-subtract divide; tready stays low from the cycle after the closing
// transfer until the quotient is loaded into the output register.
// The result shows on the master side in the cycle after that load.
// A stalled receiver holds the output register; the next run still streams
// in, but its result waits in the divider, tready low, until the register frees.
// Reset clears the means, the running sum, count and flags, and the output valid.
module paired_covariance_accumulator_top
    import pca_pkg::*;
#(
    parameter int MAX_SAMPLES = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // value_a, value_b
    input  logic [S_TUSER_W-1:0] s_axis_tuser,   // missing_a, missing_b
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // covariance, sample_count, zero pad
    output logic [M_TUSER_W-1:0] m_axis_tuser    // no_samples, saturated
);

    t_pca_cmd w_cmd;
    t_pca_sts w_sts;

    pca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tlast  (s_axis_tlast),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pca_dpath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

endmodule

// ===== bench/paired_covariance_checker.sv =====
module paired_covariance_checker
    import pca_pkg::*;
#(
    parameter int MAX_SAMPLES = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // value_a, value_b
    input  logic [S_TUSER_W-1:0] s_axis_tuser,   // missing_a, missing_b
    input  logic                 s_axis_tlast,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,   // covariance, sample_count, zero pad
    input  logic [M_TUSER_W-1:0] m_axis_tuser,   // no_samples, saturated
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO = -SUM_HI - 64'sd1;
    localparam int     REPORT_LIMIT = 10;

    typedef struct packed {
        logic [SUM_W-1:0]     covariance;
        logic [CNT_OUT_W-1:0] sample_count;
        logic                 no_samples;
        logic                 saturated;
    } cov_result_t;

    longint      mean_a_q;
    longint      mean_b_q;
    longint      cov_sum;
    int unsigned pair_cnt;
    logic        sat_seen;
    cov_result_t cov_results_q[$];
    int          mismatches;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatches   = 0;
    end

    function automatic void add_term(input longint term);
        longint s;
        s = cov_sum + term;
        if (s > SUM_HI) begin
            s = SUM_HI;
            sat_seen = 1'b1;
        end else if (s < SUM_LO) begin
            s = SUM_LO;
            sat_seen = 1'b1;
        end
        cov_sum = s;
    endfunction

    function automatic void count_pair();
        if (pair_cnt >= MAX_SAMPLES) begin
            pair_cnt = MAX_SAMPLES;
            sat_seen = 1'b1;
        end else begin
            pair_cnt++;
        end
    endfunction

    function automatic void clear_run();
        cov_sum  = 0;
        pair_cnt = 0;
        sat_seen = 1'b0;
    endfunction

    // Fold one accepted pair into the running sum; queue a result when it closes a run.
    function automatic void absorb_pair(input logic [S_TDATA_W-1:0] data,
                                        input logic [S_TUSER_W-1:0] flags,
                                        input logic                 closes);
        longint      dev_a;
        longint      dev_b;
        longint      quot;
        cov_result_t res;
        dev_a = longint'($signed(data[SAMPLE_W-1:0])) - mean_a_q;
        dev_b = longint'($signed(data[2*SAMPLE_W-1:SAMPLE_W])) - mean_b_q;
        if (!flags[0] && !flags[1]) begin
            add_term(dev_a * dev_b);
            count_pair();
        end else if (!flags[0]) begin
            add_term(dev_a * 256);
            count_pair();
        end else if (!flags[1]) begin
            add_term(dev_b * 256);
            count_pair();
        end
        if (closes) begin
            if (pair_cnt == 0) begin
                res.covariance = '0;
                res.no_samples = 1'b1;
            end else begin
                quot = cov_sum / longint'(pair_cnt);
                res.covariance = quot[SUM_W-1:0];
                res.no_samples = 1'b0;
            end
            res.saturated    = sat_seen;
            res.sample_count = pair_cnt[CNT_OUT_W-1:0];
            cov_results_q.push_back(res);
            clear_run();
        end
    endfunction

    function automatic void check_result(input logic [M_TDATA_W-1:0] data,
                                         input logic [M_TUSER_W-1:0] flags);
        cov_result_t got;
        cov_result_t want;
        got.covariance   = data[SUM_W-1:0];
        got.sample_count = data[SUM_W +: CNT_OUT_W];
        got.no_samples   = flags[0];
        got.saturated    = flags[1];
        if (cov_results_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: result with nothing pending: cov=%0d cnt=%0d empty=%b sat=%b",
                         $realtime, $signed(got.covariance), got.sample_count,
                         got.no_samples, got.saturated);
        end else begin
            want = cov_results_q.pop_front();
            if (got.covariance !== want.covariance || got.sample_count !== want.sample_count
                    || got.no_samples !== want.no_samples
                    || got.saturated !== want.saturated) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: mismatch exp cov=%0d cnt=%0d empty=%b sat=%b, got cov=%0d cnt=%0d empty=%b sat=%b",
                             $realtime, $signed(want.covariance), want.sample_count,
                             want.no_samples, want.saturated, $signed(got.covariance),
                             got.sample_count, got.no_samples, got.saturated);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mean_a_q = 0;
            mean_b_q = 0;
            clear_run();
            cov_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MEAN_A: mean_a_q = longint'($signed(i_cfg_data));
                    CFG_MEAN_B: mean_b_q = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            // check before queueing, so a result never matches the pair closing this cycle
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata, m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                absorb_pair(s_axis_tdata, s_axis_tuser, s_axis_tlast);
        end
        o_fail_count <= mismatches;
        o_pending    <= cov_results_q.size();
    end

endmodule

// ===== bench/tb_paired_covariance_accumulator_top.sv =====
module tb_paired_covariance_accumulator_top;
    import pca_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam logic [SAMPLE_W-1:0]  Q_MAX       = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0]  Q_MIN       = 16'h8000;
    localparam int RANDOM_PER_PHASE = 175;
    localparam int SETTLE_CYCLES    = 80;
    localparam int STALL_LIMIT      = 3000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // value_a, value_b
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;   // missing_a, missing_b
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // covariance, sample_count, zero pad
    logic [M_TUSER_W-1:0] m_axis_tuser;        // no_samples, saturated

    int fail_count;
    int pending;
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int quiet_cycles  = 0;

    always #6 i_clk = ~i_clk;

    paired_covariance_accumulator_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    paired_covariance_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // End the run when no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return '0;
            3: return '1;
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic push_pair(input logic [SAMPLE_W-1:0] val_a, input logic [SAMPLE_W-1:0] val_b,
                             input logic miss_a, input logic miss_b, input logic closes);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val_b, val_a};
        s_axis_tuser  <= {miss_b, miss_a};
        s_axis_tlast  <= closes;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Hold off the sender until every queued result has been delivered.
    task automatic wait_drained(input int tail);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_means(input logic [CFG_W-1:0] mean_a, input logic [CFG_W-1:0] mean_b);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MEAN_A;
        i_cfg_data <= mean_a;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MEAN_B;
        i_cfg_data <= mean_b;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic random_run(output int sent);
        int   n;
        int   pick;
        logic all_missing;
        logic miss_a;
        logic miss_b;
        n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 12);
        all_missing = ($urandom_range(0, 11) == 0);
        for (int k = 0; k < n; k++) begin
            pick   = $urandom_range(0, 99);
            miss_a = all_missing || pick >= 75;
            miss_b = all_missing || (pick >= 60 && pick < 75) || pick >= 90;
            push_pair(pick_sample(), pick_sample(), miss_a, miss_b, k == n - 1);
        end
        sent = n;
    endtask

    initial begin
        int sent;
        int issued;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // spare indexes must leave both means untouched
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SPARE_2;
        i_cfg_data <= 16'hAAAA;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SPARE_3;
        i_cfg_data <= 16'h5555;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        write_means('0, '0);

        // empty run
        push_pair(16'h1234, 16'h4321, 1'b1, 1'b1, 1'b1);
        // extremes, every presence combination
        push_pair(Q_MAX, Q_MAX, 1'b0, 1'b0, 1'b0);
        push_pair(Q_MIN, Q_MIN, 1'b0, 1'b0, 1'b0);
        push_pair(Q_MIN, Q_MAX, 1'b0, 1'b0, 1'b0);
        push_pair(Q_MAX, 16'h0001, 1'b0, 1'b1, 1'b0);
        push_pair(16'h5555, Q_MIN, 1'b1, 1'b0, 1'b0);
        push_pair(16'hAAAA, 16'h5555, 1'b1, 1'b1, 1'b0);
        push_pair('0, '0, 1'b0, 1'b0, 1'b1);
        // negative quotient truncates toward zero
        push_pair(16'h0001, 16'hFFFD, 1'b0, 1'b0, 1'b0);
        push_pair(16'h0000, 16'h0005, 1'b0, 1'b0, 1'b1);
        // lone sample closing its own run
        push_pair(Q_MIN, Q_MAX, 1'b0, 1'b1, 1'b1);
        // multi-pair run with nothing present
        push_pair(Q_MAX, Q_MIN, 1'b1, 1'b1, 1'b0);
        push_pair(Q_MIN, Q_MAX, 1'b1, 1'b1, 1'b1);
        push_pair(16'h5555, 16'hAAAA, 1'b0, 1'b0, 1'b0);
        push_pair(16'hAAAA, 16'h5555, 1'b0, 1'b0, 1'b1);
        wait_drained(SETTLE_CYCLES);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 0;  sink_stall_pct = 0;
                    write_means(pick_sample(), pick_sample());
                end
                1: begin
                    src_idle_pct = 76; sink_stall_pct = 0;
                    write_means(Q_MAX, Q_MIN);
                end
                2: begin
                    src_idle_pct = 0;  sink_stall_pct = 76;
                    write_means(SAMPLE_W'($urandom_range(0, 65535)),
                                SAMPLE_W'($urandom_range(0, 65535)));
                end
                default: begin
                    src_idle_pct = 16; sink_stall_pct = 16;
                    write_means(SAMPLE_W'($urandom_range(0, 65535)), Q_MAX);
                end
            endcase
            issued = 0;
            while (issued < RANDOM_PER_PHASE) begin
                random_run(sent);
                // pause the source now and then until all results are out
                if ((phase == 1 && issued == 0) || $urandom_range(0, 9) == 0)
                    wait_drained(0);
                issued += sent;
            end
            wait_drained(SETTLE_CYCLES);
        end

        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
